### rtl/core/kme_pkg.sv
// Shared types and constants of the Kruskal spanning tree engine.
package kme_pkg;

    localparam int NODE_BITS = 6;
    localparam int VC_BITS   = 7;
    localparam int APB_AW    = 3;

    localparam logic       OP_ADD = 1'b0;
    localparam logic       OP_RUN = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DISC  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic       REG_VERTEX_COUNT = 1'b0;
    localparam logic [7:0] VC_RESET         = 8'd6;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PUSH, S_CHECK, S_POP, S_FIND_A, S_FIND_B, S_DECIDE
    } t_top_state;

    typedef enum logic [3:0] {
        H_IDLE, H_UP_TEST, H_UP_CHK, H_POP_TOP, H_POP_MOV, H_DN_TEST, H_DN_LC, H_DN_RC
    } t_heap_state;

    typedef enum logic [1:0] {
        U_CLEAR, U_IDLE, U_WALK, U_COMP
    } t_uf_state;

    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } t_heap_cmd;

    typedef struct packed {
        logic find;
        logic link;
        logic clear;
    } t_uf_cmd;

endpackage

### rtl/core/kruskal_mst_engine.sv
// Top level of the Kruskal minimum spanning tree engine: control, registers and outputs.
//
// An add item (operation 0) pushes an edge into a min-heap held in memory, walking up
// the heap one level at a time, or is refused with a single error beat. A run item
// (operation 1) pops edges in weight order, finds both roots in the union-find table
// and emits one beat for every edge that joins two components, with the running cost.
// Each root search walks the links to the root and then compresses the path. Every run
// over more than one vertex ends with a clearing pass over all MAX_VERTICES table
// entries that puts the parent table back to identity; the same pass runs once after
// reset, and busy stays high throughout. Result beats appear on the o_ ports for exactly
// one cycle, marked by o_result_valid, and cannot be held off by the receiver. The
// vertex count register should be written only while busy is low and no beat is pending.
module kruskal_mst_engine #(
    parameter int HEAP_DEPTH   = 128,
    parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_operation,
    input  logic [kme_pkg::NODE_BITS-1:0]          i_node_a,
    input  logic [kme_pkg::NODE_BITS-1:0]          i_node_b,
    input  logic signed [WEIGHT_BITS-1:0]          i_edge_weight,
    output logic                                   o_result_valid,
    output logic                                   o_edge_valid,
    output logic [kme_pkg::NODE_BITS-1:0]          o_tree_a,
    output logic [kme_pkg::NODE_BITS-1:0]          o_tree_b,
    output logic signed [WEIGHT_BITS-1:0]          o_tree_weight,
    output logic signed [WEIGHT_BITS+kme_pkg::NODE_BITS-1:0] o_total_cost,
    output logic                                   o_last,
    output logic [1:0]                             o_status,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [kme_pkg::APB_AW-1:0]             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import kme_pkg::*;

    localparam int EW    = 2 * NODE_BITS + WEIGHT_BITS;
    localparam int CNTW  = $clog2(HEAP_DEPTH + 1);
    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int XW    = NODE_BITS + VW;
    localparam int NVW   = $clog2(MAX_VERTICES + 1);
    localparam int CW    = (NVW > VC_BITS) ? NVW : VC_BITS;
    localparam int COSTW = WEIGHT_BITS + NODE_BITS;

    // Configuration register.
    logic [VC_BITS-1:0] r_vertex_count;
    logic               cfg_wr;

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? 32'(r_vertex_count) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VC_BITS'(VC_RESET);
        end else if (cfg_wr) begin
            r_vertex_count <= pwdata[VC_BITS-1:0];
        end
    end

    // Effective vertex count: zero counts as one, and anything past the table is clipped.
    logic [CW-1:0] vc_x, nv_x;

    assign vc_x = CW'(r_vertex_count);
    always_comb begin
        if (vc_x == '0) begin
            nv_x = CW'(1);
        end else if (vc_x > CW'(MAX_VERTICES)) begin
            nv_x = CW'(MAX_VERTICES);
        end else begin
            nv_x = vc_x;
        end
    end

    // Heap and union-find units.
    t_heap_cmd       heap_cmd;
    logic [EW-1:0]   heap_top;
    logic [CNTW-1:0] heap_count;
    logic            heap_idle;
    t_uf_cmd         uf_cmd;
    logic [VW-1:0]   uf_x, uf_y, uf_root;
    logic            uf_ready;

    kme_heap #(
        .HEAP_DEPTH  (HEAP_DEPTH),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_heap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (heap_cmd),
        .i_entry ({i_node_a, i_node_b, i_edge_weight}),
        .o_top   (heap_top),
        .o_count (heap_count),
        .o_idle  (heap_idle)
    );

    kme_uf #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_uf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (uf_cmd),
        .i_x     (uf_x),
        .i_y     (uf_y),
        .o_root  (uf_root),
        .o_ready (uf_ready)
    );

    // Control state and the edge under test.
    t_top_state        r_state, n_state;
    logic [EW-1:0]     r_edge, n_edge;
    logic [VW-1:0]     r_ra, n_ra;
    logic [CW-1:0]     r_taken, n_taken;
    logic [COSTW-1:0]  r_cost, n_cost;

    // Output beat registers.
    logic              r_valid, n_valid;
    logic              r_ev, n_ev;
    logic [NODE_BITS-1:0] r_a, n_a, r_b, n_b;
    logic [WEIGHT_BITS-1:0] r_w, n_w;
    logic [COSTW-1:0]  r_ocost, n_ocost;
    logic              r_last, n_last;
    logic [1:0]        r_status, n_status;

    logic [NODE_BITS-1:0]   edge_a, edge_b;
    logic [WEIGHT_BITS-1:0] edge_w;
    logic [XW-1:0]          xa, xb;
    logic [COSTW-1:0]       cost_sum;
    logic                   tree_done;
    logic                   accept;

    assign edge_a   = r_edge[EW-1 -: NODE_BITS];
    assign edge_b   = r_edge[WEIGHT_BITS +: NODE_BITS];
    assign edge_w   = r_edge[WEIGHT_BITS-1:0];
    assign xa       = XW'(edge_a);
    assign xb       = XW'(edge_b);
    assign cost_sum = r_cost + {{(COSTW - WEIGHT_BITS){edge_w[WEIGHT_BITS-1]}}, edge_w};
    assign tree_done = (r_taken + CW'(1)) >= (nv_x - CW'(1));
    assign accept   = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_edge   <= n_edge;
        r_ra     <= n_ra;
        r_taken  <= n_taken;
        r_cost   <= n_cost;
        r_ev     <= n_ev;
        r_a      <= n_a;
        r_b      <= n_b;
        r_w      <= n_w;
        r_ocost  <= n_ocost;
        r_last   <= n_last;
        r_status <= n_status;
    end

    always_comb begin
        n_state  = r_state;
        n_edge   = r_edge;
        n_ra     = r_ra;
        n_taken  = r_taken;
        n_cost   = r_cost;
        n_valid  = 1'b0;
        n_ev     = 1'b0;
        n_a      = '0;
        n_b      = '0;
        n_w      = '0;
        n_ocost  = '0;
        n_last   = 1'b0;
        n_status = ST_OK;
        heap_cmd = '0;
        uf_cmd   = '0;
        uf_x     = xa[VW-1:0];
        uf_y     = '0;
        unique case (r_state)
            S_CLEAR: begin
                if (uf_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_operation == OP_ADD) begin
                        // The range check is made before the full check.
                        if (CW'(i_node_a) >= nv_x || CW'(i_node_b) >= nv_x) begin
                            n_valid  = 1'b1;
                            n_last   = 1'b1;
                            n_status = ST_RANGE;
                        end else if (heap_count == CNTW'(HEAP_DEPTH)) begin
                            n_valid  = 1'b1;
                            n_last   = 1'b1;
                            n_status = ST_FULL;
                        end else begin
                            heap_cmd.push = 1'b1;
                            n_state       = S_PUSH;
                        end
                    end else begin
                        n_taken = '0;
                        n_cost  = '0;
                        if (nv_x == CW'(1)) begin
                            // A single vertex needs no edges; the heap is simply dropped.
                            n_valid        = 1'b1;
                            n_last         = 1'b1;
                            heap_cmd.flush = 1'b1;
                        end else begin
                            n_state = S_CHECK;
                        end
                    end
                end
            end
            S_PUSH: begin
                if (heap_idle) begin
                    n_state = S_IDLE;
                end
            end
            S_CHECK: begin
                if (heap_count == '0) begin
                    // The heap ran dry before the tree was complete.
                    n_valid      = 1'b1;
                    n_last       = 1'b1;
                    n_status     = ST_DISC;
                    n_ocost      = r_cost;
                    uf_cmd.clear = 1'b1;
                    n_state      = S_CLEAR;
                end else begin
                    heap_cmd.pop = 1'b1;
                    n_state      = S_POP;
                end
            end
            S_POP: begin
                if (heap_idle) begin
                    n_edge  = heap_top;
                    n_state = S_FIND_A;
                end
            end
            S_FIND_A: begin
                uf_cmd.find = 1'b1;
                uf_x        = xa[VW-1:0];
                n_state     = S_FIND_B;
            end
            S_FIND_B: begin
                if (uf_ready) begin
                    n_ra        = uf_root;
                    uf_cmd.find = 1'b1;
                    uf_x        = xb[VW-1:0];
                    n_state     = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (uf_ready) begin
                    if (r_ra != uf_root) begin
                        n_cost  = cost_sum;
                        n_taken = r_taken + CW'(1);
                        n_valid = 1'b1;
                        n_ev    = 1'b1;
                        n_a     = edge_a;
                        n_b     = edge_b;
                        n_w     = edge_w;
                        n_ocost = cost_sum;
                        if (tree_done) begin
                            // Tree complete: drop the rest of the heap and reset the table.
                            n_last         = 1'b1;
                            heap_cmd.flush = 1'b1;
                            uf_cmd.clear   = 1'b1;
                            n_state        = S_CLEAR;
                        end else begin
                            uf_cmd.link = 1'b1;
                            uf_x        = r_ra;
                            uf_y        = uf_root;
                            n_state     = S_CHECK;
                        end
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_valid;
    assign o_edge_valid   = r_ev;
    assign o_tree_a       = r_a;
    assign o_tree_b       = r_b;
    assign o_tree_weight  = r_w;
    assign o_total_cost   = r_ocost;
    assign o_last         = r_last;
    assign o_status       = r_status;

    // The sub-units must be at rest whenever the block reports itself free.
    a_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> (heap_idle && uf_ready))
        else $error("unit still working while block is free");

    // A tree edge is only ever carried by a valid beat with status ok.
    a_edge_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_edge_valid |-> (o_result_valid && o_status == ST_OK))
        else $error("tree edge without valid ok beat");

    // Refused adds end their item at once and carry no edge.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status == ST_FULL || o_status == ST_RANGE))
        |-> (o_last && !o_edge_valid))
        else $error("error beat not final");

    // An accepted run either answers at once or keeps the block busy.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_operation == OP_RUN) |=> (busy || o_result_valid))
        else $error("run accepted without effect");

endmodule

### rtl/core/kme_heap.sv
// Binary min-heap of edges held in one synchronous memory, with sift-up and sift-down.
module kme_heap #(
    parameter int HEAP_DEPTH  = 128,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  kme_pkg::t_heap_cmd                         i_cmd,
    input  logic [2*kme_pkg::NODE_BITS+WEIGHT_BITS-1:0] i_entry,
    output logic [2*kme_pkg::NODE_BITS+WEIGHT_BITS-1:0] o_top,
    output logic [$clog2(HEAP_DEPTH+1)-1:0]            o_count,
    output logic                                       o_idle
);
    import kme_pkg::*;

    localparam int EW   = 2 * NODE_BITS + WEIGHT_BITS;
    localparam int CNTW = $clog2(HEAP_DEPTH + 1);
    localparam int PW   = CNTW + 1;
    localparam int AW   = $clog2(HEAP_DEPTH);

    logic [EW-1:0]   mem [HEAP_DEPTH];
    logic [EW-1:0]   q;
    logic [PW-1:0]   raddr, waddr;
    logic [EW-1:0]   wdata;
    logic            we;

    t_heap_state     r_state, n_state;
    logic [CNTW-1:0] r_count, n_count;
    logic [PW-1:0]   r_pos, n_pos;
    logic [PW-1:0]   r_ch, n_ch;
    logic [EW-1:0]   r_mov, n_mov;
    logic [EW-1:0]   r_top, n_top;
    logic [EW-1:0]   r_lc, n_lc;

    logic [EW-1:0]   cw;
    logic [PW-1:0]   cpos;
    logic [PW-1:0]   cnt_x;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[AW'(waddr - PW'(1))] <= wdata;
        end
        q <= mem[AW'(raddr - PW'(1))];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_pos <= n_pos;
        r_ch  <= n_ch;
        r_mov <= n_mov;
        r_top <= n_top;
        r_lc  <= n_lc;
    end

    assign cnt_x = PW'(r_count);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_pos   = r_pos;
        n_ch    = r_ch;
        n_mov   = r_mov;
        n_top   = r_top;
        n_lc    = r_lc;
        raddr   = r_pos;
        waddr   = r_pos;
        wdata   = r_mov;
        we      = 1'b0;
        cw      = q;
        cpos    = r_ch;
        unique case (r_state)
            H_IDLE: begin
                if (i_cmd.flush) begin
                    n_count = '0;
                end else if (i_cmd.push) begin
                    n_count = r_count + CNTW'(1);
                    n_pos   = cnt_x + PW'(1);
                    n_mov   = i_entry;
                    n_state = H_UP_TEST;
                end else if (i_cmd.pop) begin
                    raddr   = PW'(1);
                    n_state = H_POP_TOP;
                end
            end
            H_UP_TEST: begin
                if (r_pos == PW'(1)) begin
                    we      = 1'b1;
                    n_state = H_IDLE;
                end else begin
                    raddr   = r_pos >> 1;
                    n_state = H_UP_CHK;
                end
            end
            H_UP_CHK: begin
                we = 1'b1;
                if ($signed(r_mov[WEIGHT_BITS-1:0]) < $signed(q[WEIGHT_BITS-1:0])) begin
                    wdata   = q;
                    n_pos   = r_pos >> 1;
                    n_state = H_UP_TEST;
                end else begin
                    n_state = H_IDLE;
                end
            end
            H_POP_TOP: begin
                n_top   = q;
                raddr   = cnt_x;
                n_state = H_POP_MOV;
            end
            H_POP_MOV: begin
                n_mov   = q;
                n_count = r_count - CNTW'(1);
                n_pos   = PW'(1);
                n_ch    = PW'(2);
                n_state = H_DN_TEST;
            end
            H_DN_TEST: begin
                if (r_ch > cnt_x) begin
                    we      = 1'b1;
                    n_state = H_IDLE;
                end else begin
                    raddr   = r_ch;
                    n_state = H_DN_LC;
                end
            end
            H_DN_LC, H_DN_RC: begin
                if (r_state == H_DN_LC && r_ch < cnt_x) begin
                    n_lc    = q;
                    raddr   = r_ch + PW'(1);
                    n_state = H_DN_RC;
                end else begin
                    if (r_state == H_DN_RC) begin
                        if ($signed(r_lc[WEIGHT_BITS-1:0]) > $signed(q[WEIGHT_BITS-1:0])) begin
                            cw   = q;
                            cpos = r_ch + PW'(1);
                        end else begin
                            cw = r_lc;
                        end
                    end
                    we = 1'b1;
                    if ($signed(r_mov[WEIGHT_BITS-1:0]) <= $signed(cw[WEIGHT_BITS-1:0])) begin
                        n_state = H_IDLE;
                    end else begin
                        wdata   = cw;
                        n_pos   = cpos;
                        n_ch    = cpos << 1;
                        n_state = H_DN_TEST;
                    end
                end
            end
            default: n_state = H_IDLE;
        endcase
    end

    assign o_top   = r_top;
    assign o_count = r_count;
    assign o_idle  = (r_state == H_IDLE);

endmodule

### rtl/core/kme_uf.sv
// Union-find parent table in one synchronous memory: root search, compression, link, clear.
module kme_uf #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  kme_pkg::t_uf_cmd                 i_cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0]  i_x,
    input  logic [$clog2(MAX_VERTICES)-1:0]  i_y,
    output logic [$clog2(MAX_VERTICES)-1:0]  o_root,
    output logic                             o_ready
);
    import kme_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);

    logic [VW-1:0] mem [MAX_VERTICES];
    logic [VW-1:0] q, raddr, waddr, wdata;
    logic          we;

    t_uf_state     r_state, n_state;
    logic [VW-1:0] r_x, n_x;
    logic [VW-1:0] r_r, n_r;
    logic [VW-1:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        q <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_CLEAR;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
        r_x <= n_x;
        r_r <= n_r;
    end

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_r     = r_r;
        n_idx   = r_idx;
        raddr   = r_r;
        waddr   = r_x;
        wdata   = r_r;
        we      = 1'b0;
        unique case (r_state)
            U_IDLE: begin
                if (i_cmd.clear) begin
                    n_idx   = '0;
                    n_state = U_CLEAR;
                end else if (i_cmd.link) begin
                    we    = 1'b1;
                    waddr = i_y;
                    wdata = i_x;
                end else if (i_cmd.find) begin
                    n_x     = i_x;
                    n_r     = i_x;
                    raddr   = i_x;
                    n_state = U_WALK;
                end
            end
            U_WALK: begin
                if (q != r_r) begin
                    n_r   = q;
                    raddr = q;
                end else if (r_x == r_r) begin
                    n_state = U_IDLE;
                end else begin
                    raddr   = r_x;
                    n_state = U_COMP;
                end
            end
            U_COMP: begin
                we = 1'b1;
                if (q == r_r) begin
                    n_state = U_IDLE;
                end else begin
                    n_x   = q;
                    raddr = q;
                end
            end
            U_CLEAR: begin
                we    = 1'b1;
                waddr = r_idx;
                wdata = r_idx;
                if (r_idx == VW'(MAX_VERTICES - 1)) begin
                    n_state = U_IDLE;
                end else begin
                    n_idx = r_idx + VW'(1);
                end
            end
            default: n_state = U_IDLE;
        endcase
    end

    assign o_root  = r_r;
    assign o_ready = (r_state == U_IDLE);

endmodule
